// ===== src/aptw_pkg.sv =====
package aptw_pkg;

    localparam int MAX_THREADS = 64;
    localparam int MAX_RESULTS = 32;

    localparam int RATE_W    = 32;
    localparam int THREAD_W  = 7;
    localparam int FIRST_W   = 6;
    localparam int DIVISOR_W = 8;
    localparam int LIMIT_W   = 8;
    localparam int COUNT_W   = 16;
    localparam int WAKE_W    = 6;
    localparam int LEFT_W    = $clog2(MAX_RESULTS + 1);

    // dividend of the shared divider: (window + 1) * 16 fits 12 bits
    localparam int DIV_W     = 12;
    localparam int STEP_W    = $clog2(DIV_W);

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_THREAD_COUNT     = 2'd0,
        REG_WINDOW_FIRST     = 2'd1,
        REG_DECREASE_DIVISOR = 2'd2,
        REG_DROP_LIMIT       = 2'd3
    } cfg_reg_t;

    localparam logic [THREAD_W-1:0]  THREAD_COUNT_RST = 7'd64;
    localparam logic [FIRST_W-1:0]   WINDOW_FIRST_RST = 6'd0;
    localparam logic [DIVISOR_W-1:0] DIVISOR_RST      = 8'd32;
    localparam logic [LIMIT_W-1:0]   DROP_LIMIT_RST   = 8'd1;

    typedef struct packed {
        logic load_rate;
        logic evaluate;
        logic finish_div;
        logic advance;
    } aptw_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_busy;
        logic last_result;
    } aptw_status_t;

endpackage

// ===== src/aptw_if.sv =====
interface aptw_sample_if import aptw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] rate;

    modport source (output valid, output rate, input ready);
    modport sink   (input valid, input rate, output ready);
endinterface

interface aptw_result_if import aptw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                wake_valid;
    logic [WAKE_W-1:0]   wake_thread;
    logic [THREAD_W-1:0] window_now;
    logic [COUNT_W-1:0]  decrease_events;
    logic [COUNT_W-1:0]  avoided_decreases;
    logic                last;

    modport source (output valid, output wake_valid, output wake_thread, output window_now,
                    output decrease_events, output avoided_decreases, output last,
                    input ready);
    modport sink   (input valid, input wake_valid, input wake_thread, input window_now,
                    input decrease_events, input avoided_decreases, input last,
                    output ready);
endinterface

// ===== src/aptw_div.sv =====
module aptw_div import aptw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                 busy,
    output logic [DIV_W-1:0]     quotient,
    output logic [DIVISOR_W-1:0] remainder
);

    logic [DIV_W-1:0]     quo_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] div_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 busy_reg;

    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;

    // one restoring step per cycle, MSB first; a zero divisor yields all ones
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(DIV_W - 1);
        end
        else if (busy_reg) begin
            if (step_reg == '0) begin
                busy_reg <= 1'b0;
            end
            else begin
                step_reg <= step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

// ===== src/aptw_ctrl.sv =====
module aptw_ctrl import aptw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  aptw_status_t status,
    output aptw_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;
    logic   out_valid_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_valid && in_ready_reg) begin
                        state_reg    <= ST_EVAL;
                        in_ready_reg <= 1'b0;
                    end
                end
                ST_EVAL: begin
                    if (status.need_div) begin
                        state_reg <= ST_DIV;
                    end
                    else begin
                        state_reg     <= ST_EMIT;
                        out_valid_reg <= 1'b1;
                    end
                end
                ST_DIV: begin
                    if (!status.div_busy) begin
                        state_reg     <= ST_EMIT;
                        out_valid_reg <= 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (out_ready && status.last_result) begin
                        state_reg     <= ST_IDLE;
                        out_valid_reg <= 1'b0;
                        in_ready_reg  <= 1'b1;
                    end
                end
                default: begin
                    state_reg     <= ST_IDLE;
                    out_valid_reg <= 1'b0;
                    in_ready_reg  <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        cmd.load_rate  = (state_reg == ST_IDLE) && in_valid && in_ready_reg;
        cmd.evaluate   = (state_reg == ST_EVAL);
        cmd.finish_div = (state_reg == ST_DIV) && !status.div_busy;
        cmd.advance    = (state_reg == ST_EMIT) && out_ready;
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready_reg && out_valid_reg))
        else $error("input taken while a result is pending");

endmodule

// ===== src/aptw_dp.sv =====
module aptw_dp import aptw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    input  logic [RATE_W-1:0]      rate,
    input  aptw_cmd_t              cmd,
    output aptw_status_t           status,
    output logic                   wake_valid,
    output logic [WAKE_W-1:0]      wake_thread,
    output logic [THREAD_W-1:0]    window_now,
    output logic [COUNT_W-1:0]     decrease_events,
    output logic [COUNT_W-1:0]     avoided_decreases,
    output logic                   last
);

    logic [THREAD_W-1:0]  thread_count_reg;
    logic [FIRST_W-1:0]   window_first_reg;
    logic [DIVISOR_W-1:0] divisor_reg;
    logic [LIMIT_W-1:0]   drop_limit_reg;

    logic [THREAD_W-1:0]  window_reg;
    logic                 slow_start_reg;
    logic [RATE_W-1:0]    previous_rate_reg;
    logic [RATE_W-1:0]    older_rate_reg;
    logic                 probe_pending_reg;
    logic [LIMIT_W-1:0]   drop_count_reg;
    logic [COUNT_W-1:0]   decrease_total_reg;
    logic [COUNT_W-1:0]   avoided_total_reg;

    logic [RATE_W-1:0]    rate_reg;
    logic                 wake_mode_reg;
    logic                 cut_mode_reg;
    logic [THREAD_W-1:0]  wake_idx_reg;
    logic [LEFT_W-1:0]    wake_left_reg;

    logic [THREAD_W-1:0]  n_eff;
    logic                 grow;
    logic [THREAD_W:0]    target_raw;
    logic [THREAD_W-1:0]  target;
    logic                 adds;
    logic [THREAD_W-1:0]  added;
    logic [LEFT_W-1:0]    wake_cnt;
    logic                 probe;
    logic [LIMIT_W-1:0]   limit;
    logic [LIMIT_W-1:0]   drop_inc;
    logic                 fire;
    logic                 need_div;
    logic                 div_start;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
    logic                 div_busy;
    logic [DIV_W-1:0]     quotient;
    logic [DIVISOR_W-1:0] remainder;
    logic [THREAD_W-1:0]  lower;
    logic [THREAD_W-1:0]  cut_pre;
    logic [THREAD_W-1:0]  cut;
    logic [THREAD_W-1:0]  idx_inc;
    logic [THREAD_W:0]    start_sum;
    logic [THREAD_W:0]    window_inc;

    always_comb begin
        if (thread_count_reg == '0) begin
            n_eff = THREAD_W'(1);
        end
        else if (thread_count_reg > THREAD_W'(MAX_THREADS)) begin
            n_eff = THREAD_W'(MAX_THREADS);
        end
        else begin
            n_eff = thread_count_reg;
        end
    end

    always_comb begin
        grow       = (window_reg == THREAD_W'(1)) || (rate_reg > previous_rate_reg);
        target_raw = slow_start_reg ? {window_reg, 1'b0} : ({1'b0, window_reg} + 1'b1);
        target     = (target_raw > {1'b0, n_eff}) ? n_eff : target_raw[THREAD_W-1:0];
        adds       = window_reg < target;
        added      = target - window_reg;
        wake_cnt   = (added > THREAD_W'(MAX_RESULTS)) ? LEFT_W'(MAX_RESULTS)
                                                      : added[LEFT_W-1:0];
        probe      = !grow && !probe_pending_reg && !slow_start_reg;
        limit      = (drop_limit_reg == '0) ? LIMIT_W'(1) : drop_limit_reg;
        drop_inc   = (drop_count_reg != '1) ? drop_count_reg + 1'b1 : drop_count_reg;
        fire       = drop_inc >= limit;
        need_div   = grow ? adds : (!probe && fire);
        div_start  = cmd.evaluate && need_div;
    end

    // growth: first wake index is (first + old window) mod N
    // decrease: quotient of (window + 1) * 16 over the Q4.4 divisor
    always_comb begin
        start_sum  = {2'b00, window_first_reg} + {1'b0, window_reg};
        window_inc = {1'b0, window_reg} + 1'b1;
        if (grow) begin
            dividend = {{(DIV_W - THREAD_W - 1){1'b0}}, start_sum};
            divisor  = {{(DIVISOR_W - THREAD_W){1'b0}}, n_eff};
        end
        else begin
            dividend = {window_inc, 4'b0000};
            divisor  = divisor_reg;
        end
    end

    aptw_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (dividend),
        .divisor   (divisor),
        .busy      (div_busy),
        .quotient  (quotient),
        .remainder (remainder)
    );

    always_comb begin
        lower   = window_reg - 1'b1;
        cut_pre = (quotient > {{(DIV_W - THREAD_W){1'b0}}, lower}) ? lower
                                                                  : quotient[THREAD_W-1:0];
        cut     = (cut_pre == '0) ? THREAD_W'(1) : cut_pre;
        idx_inc = wake_idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            thread_count_reg <= THREAD_COUNT_RST;
            window_first_reg <= WINDOW_FIRST_RST;
            divisor_reg      <= DIVISOR_RST;
            drop_limit_reg   <= DROP_LIMIT_RST;
        end
        else if (wr_en) begin
            case (cfg_reg_t'(wr_index))
                REG_THREAD_COUNT:     thread_count_reg <= wr_data[THREAD_W-1:0];
                REG_WINDOW_FIRST:     window_first_reg <= wr_data[FIRST_W-1:0];
                REG_DECREASE_DIVISOR: divisor_reg      <= wr_data[DIVISOR_W-1:0];
                REG_DROP_LIMIT:       drop_limit_reg   <= wr_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            window_reg         <= THREAD_W'(1);
            slow_start_reg     <= 1'b1;
            previous_rate_reg  <= '0;
            older_rate_reg     <= '0;
            probe_pending_reg  <= 1'b0;
            drop_count_reg     <= '0;
            decrease_total_reg <= '0;
            avoided_total_reg  <= '0;
            wake_mode_reg      <= 1'b0;
            cut_mode_reg       <= 1'b0;
            wake_left_reg      <= '0;
        end
        else if (cmd.evaluate) begin
            cut_mode_reg  <= 1'b0;
            wake_mode_reg <= 1'b0;
            if (grow) begin
                if (probe_pending_reg) begin
                    avoided_total_reg <= (avoided_total_reg != '1) ? avoided_total_reg + 1'b1
                                                                   : avoided_total_reg;
                    probe_pending_reg <= 1'b0;
                end
                drop_count_reg <= '0;
                if (adds) begin
                    older_rate_reg    <= previous_rate_reg;
                    previous_rate_reg <= rate_reg;
                    window_reg        <= target;
                    wake_left_reg     <= wake_cnt;
                    wake_mode_reg     <= 1'b1;
                end
            end
            else if (probe) begin
                window_reg        <= window_reg - 1'b1;
                previous_rate_reg <= older_rate_reg;
                probe_pending_reg <= 1'b1;
            end
            else if (fire) begin
                cut_mode_reg <= 1'b1;
            end
            else begin
                drop_count_reg <= drop_inc;
            end
        end
        else if (cmd.finish_div) begin
            if (cut_mode_reg) begin
                window_reg         <= cut;
                previous_rate_reg  <= '0;
                older_rate_reg     <= '0;
                probe_pending_reg  <= 1'b0;
                drop_count_reg     <= '0;
                decrease_total_reg <= (decrease_total_reg != '1) ? decrease_total_reg + 1'b1
                                                                 : decrease_total_reg;
                slow_start_reg     <= 1'b0;
            end
        end
        else if (cmd.advance && wake_mode_reg && !status.last_result) begin
            wake_left_reg <= wake_left_reg - 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.load_rate) begin
            rate_reg <= rate;
        end
        if (cmd.finish_div && !cut_mode_reg) begin
            wake_idx_reg <= remainder[THREAD_W-1:0];
        end
        else if (cmd.advance && wake_mode_reg && !status.last_result) begin
            wake_idx_reg <= (idx_inc == n_eff) ? '0 : idx_inc;
        end
    end

    always_comb begin
        status.need_div    = need_div;
        status.div_busy    = div_busy;
        status.last_result = !wake_mode_reg || (wake_left_reg == LEFT_W'(1));
    end

    assign wake_valid        = wake_mode_reg;
    assign wake_thread       = wake_mode_reg ? wake_idx_reg[WAKE_W-1:0] : '0;
    assign window_now        = window_reg;
    assign decrease_events   = decrease_total_reg;
    assign avoided_decreases = avoided_total_reg;
    assign last              = status.last_result;

    a_window_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        window_reg != '0)
        else $error("window size reached zero");

    a_cut_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish_div && cut_mode_reg) |=> window_reg < $past(window_reg))
        else $error("multiplicative decrease did not shrink the window");

    a_wake_left_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        wake_left_reg <= LEFT_W'(MAX_RESULTS))
        else $error("pending wake count above result limit");

endmodule

// ===== src/aimd_probe_thread_window_control_top.sv =====
// Channel   Dir  Payload                                                Accepted when
// sample    in   rate (Q24.8)                                           valid & ready
// result    out  wake_valid/thread, window_now, both counters, last     valid & ready
// config    in   wr_index, wr_data                                      wr_en
//
// One request is handled at a time; sample.ready stays low until its last result leaves.
// Without a divide the request passes the evaluate state to its single result. Growth
// with wakes and a multiplicative decrease run the shared 12-step restoring divider
// before the first result; later results follow one per cycle while result.ready is
// high. Stalls on result.ready hold the current result and delay the next request.
// Reset clears all control and window state.
module aimd_probe_thread_window_control_top import aptw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    aptw_sample_if.sink            sample,
    aptw_result_if.source          result,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data
);

    aptw_cmd_t    cmd;
    aptw_status_t status;

    // Sequencer: idle, evaluate the rate, wait on the divider, emit results.
    aptw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Window state, config registers, divider and the result payload. The
    // payload comes straight from registers, so it holds while stalled.
    aptw_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .wr_en             (wr_en),
        .wr_index          (wr_index),
        .wr_data           (wr_data),
        .rate              (sample.rate),
        .cmd               (cmd),
        .status            (status),
        .wake_valid        (result.wake_valid),
        .wake_thread       (result.wake_thread),
        .window_now        (result.window_now),
        .decrease_events   (result.decrease_events),
        .avoided_decreases (result.avoided_decreases),
        .last              (result.last)
    );

endmodule

// ===== tb/thread_window_checker.sv =====
`timescale 1ns / 100ps

module thread_window_checker import aptw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    aptw_sample_if                 sample,
    aptw_result_if                 result,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output int                     failures,
    output int                     outstanding,
    output int                     results_checked,
    output int                     wakes_checked
);

    typedef struct packed {
        logic                wake_valid;
        logic [WAKE_W-1:0]   wake_thread;
        logic [THREAD_W-1:0] window_now;
        logic [COUNT_W-1:0]  decrease_events;
        logic [COUNT_W-1:0]  avoided_decreases;
        logic                last;
    } window_report_t;

    window_report_t expected_reports[$];

    // register copies
    logic [THREAD_W-1:0]  threads_cfg;
    logic [FIRST_W-1:0]   first_cfg;
    logic [DIVISOR_W-1:0] divisor_cfg;
    logic [LIMIT_W-1:0]   drop_limit_cfg;

    // window state
    logic [THREAD_W-1:0] win;
    logic                in_slow_start;
    logic [RATE_W-1:0]   last_rate;
    logic [RATE_W-1:0]   rate_before;
    logic                probing;
    logic [LIMIT_W-1:0]  drops_seen;
    logic [COUNT_W-1:0]  cut_total;
    logic [COUNT_W-1:0]  saved_total;

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t ns: %s got %0d, want %0d", $time, field, got, want);
        failures++;
    endtask

    // Work out the results of one rate sample and queue them.
    task automatic advance_window(input logic [RATE_W-1:0] rate);
        int             n;
        int             target;
        int             limit;
        int             cut;
        int             wake_ids[$];
        window_report_t rep;

        n = int'(threads_cfg);
        if (n < 1)
            n = 1;
        if (n > MAX_THREADS)
            n = MAX_THREADS;

        if (win == 1 || rate > last_rate)
        begin
            if (probing)
            begin
                if (saved_total != 16'hFFFF)
                    saved_total++;
                probing = 1'b0;
            end
            drops_seen = '0;
            target = in_slow_start ? 2 * int'(win) : int'(win) + 1;
            if (target > n)
                target = n;
            if (int'(win) < target)
            begin
                rate_before = last_rate;
                last_rate = rate;
                while (int'(win) < target)
                begin
                    win++;
                    if (wake_ids.size() < MAX_RESULTS)
                        wake_ids.push_back((int'(first_cfg) + int'(win) - 1) % n);
                end
            end
        end
        else if (!probing && !in_slow_start)
        begin
            // probe: step back by one and fall back to the older rate
            win--;
            last_rate = rate_before;
            probing = 1'b1;
        end
        else
        begin
            limit = (drop_limit_cfg == 0) ? 1 : int'(drop_limit_cfg);
            if (drops_seen != 8'hFF)
                drops_seen++;
            if (int'(drops_seen) >= limit)
            begin
                if (divisor_cfg == 0)
                    cut = int'(win) - 1;
                else
                    cut = ((int'(win) + 1) * 16) / int'(divisor_cfg);
                if (cut > int'(win) - 1)
                    cut = int'(win) - 1;
                if (cut < 1)
                    cut = 1;
                win = cut[THREAD_W-1:0];
                last_rate = '0;
                rate_before = '0;
                probing = 1'b0;
                drops_seen = '0;
                if (cut_total != 16'hFFFF)
                    cut_total++;
                in_slow_start = 1'b0;
            end
        end

        rep.window_now = win;
        rep.decrease_events = cut_total;
        rep.avoided_decreases = saved_total;
        if (wake_ids.size() == 0)
        begin
            rep.wake_valid = 1'b0;
            rep.wake_thread = '0;
            rep.last = 1'b1;
            expected_reports.push_back(rep);
        end
        else
        begin
            foreach (wake_ids[k])
            begin
                rep.wake_valid = 1'b1;
                rep.wake_thread = wake_ids[k][WAKE_W-1:0];
                rep.last = (k == wake_ids.size() - 1);
                expected_reports.push_back(rep);
            end
        end
    endtask

    task automatic check_result();
        window_report_t want;
        if (expected_reports.size() == 0)
        begin
            report_mismatch("result with nothing pending, window_now",
                            int'(result.window_now), 0);
        end
        else
        begin
            want = expected_reports.pop_front();
            results_checked++;
            if (want.wake_valid)
                wakes_checked++;
            if (result.wake_valid !== want.wake_valid)
                report_mismatch("wake_valid", int'(result.wake_valid),
                                int'(want.wake_valid));
            if (result.wake_thread !== want.wake_thread)
                report_mismatch("wake_thread", int'(result.wake_thread),
                                int'(want.wake_thread));
            if (result.window_now !== want.window_now)
                report_mismatch("window_now", int'(result.window_now),
                                int'(want.window_now));
            if (result.decrease_events !== want.decrease_events)
                report_mismatch("decrease_events", int'(result.decrease_events),
                                int'(want.decrease_events));
            if (result.avoided_decreases !== want.avoided_decreases)
                report_mismatch("avoided_decreases", int'(result.avoided_decreases),
                                int'(want.avoided_decreases));
            if (result.last !== want.last)
                report_mismatch("last", int'(result.last), int'(want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threads_cfg = THREAD_COUNT_RST;
            first_cfg = WINDOW_FIRST_RST;
            divisor_cfg = DIVISOR_RST;
            drop_limit_cfg = DROP_LIMIT_RST;
            win = 7'd1;
            in_slow_start = 1'b1;
            last_rate = '0;
            rate_before = '0;
            probing = 1'b0;
            drops_seen = '0;
            cut_total = '0;
            saved_total = '0;
            expected_reports.delete();
            failures = 0;
            results_checked = 0;
            wakes_checked = 0;
            outstanding = 0;
        end
        else
        begin
            // older requests drain first, so check results before queueing new ones
            if (result.valid && result.ready)
                check_result();
            if (wr_en)
            begin
                case (cfg_reg_t'(wr_index))
                    REG_THREAD_COUNT:     threads_cfg = wr_data[THREAD_W-1:0];
                    REG_WINDOW_FIRST:     first_cfg = wr_data[FIRST_W-1:0];
                    REG_DECREASE_DIVISOR: divisor_cfg = wr_data[DIVISOR_W-1:0];
                    REG_DROP_LIMIT:       drop_limit_cfg = wr_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (sample.valid && sample.ready)
                advance_window(sample.rate);
            outstanding = expected_reports.size();
        end
    end

endmodule

// ===== tb/aimd_probe_thread_window_control_top_tb.sv =====
`timescale 1ns / 100ps

module aimd_probe_thread_window_control_top_tb;
    import aptw_pkg::*;

    localparam int CYCLE_LIMIT     = 800000;
    localparam int RANDOM_PHASES   = 12;
    localparam int RATES_PER_PHASE = 42;
    localparam int TAIL_CYCLES     = 40;

    logic clk = 1'b0;
    logic rst_n;

    logic                   wr_en;
    logic [CFG_INDEX_W-1:0] wr_index;
    logic [CFG_DATA_W-1:0]  wr_data;

    aptw_sample_if sample_ch ();
    aptw_result_if result_ch ();

    int failures;
    int outstanding;
    int results_checked;
    int wakes_checked;

    // idle odds in percent, per side
    int send_idle_pct = 33;
    int recv_idle_pct = 51;

    int                rates_sent = 0;
    int                settings_used = 0;
    int                cycle_count = 0;
    logic [RATE_W-1:0] prev_sent = '0;

    aimd_probe_thread_window_control_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample_ch),
        .result   (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    thread_window_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample          (sample_ch),
        .result          (result_ch),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .failures        (failures),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .wakes_checked   (wakes_checked)
    );

    always #4 clk = ~clk;

    // Stop a hung run: the slowest legal run is far below this.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, outstanding);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver side: drop ready at random, one decision per falling edge.
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one rate request, idling first at random; return on the falling edge
    // after acceptance with valid still high, so back-to-back requests never
    // lower and raise valid in one step.
    task automatic send_rate(input logic [RATE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.rate  <= value;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        @(negedge clk);
        rates_sent++;
        prev_sent = value;
    endtask

    // Hold off new requests until every expected result has come back.
    task automatic drain();
        sample_ch.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_one(input cfg_reg_t index, input logic [CFG_DATA_W-1:0] value);
        wr_en    <= 1'b1;
        wr_index <= index;
        wr_data  <= value;
        @(negedge clk);
    endtask

    // Registers only change while the block is idle.
    task automatic write_settings(input logic [CFG_DATA_W-1:0] threads,
                                  input logic [CFG_DATA_W-1:0] first,
                                  input logic [CFG_DATA_W-1:0] divisor,
                                  input logic [CFG_DATA_W-1:0] limit);
        drain();
        write_one(REG_THREAD_COUNT, threads);
        write_one(REG_WINDOW_FIRST, first);
        write_one(REG_DECREASE_DIVISOR, divisor);
        write_one(REG_DROP_LIMIT, limit);
        wr_en <= 1'b0;
        settings_used++;
    endtask

    // Pick the low end, the high end, or anything in between.
    function automatic logic [CFG_DATA_W-1:0] pick_setting(input int low, input int high);
        case ($urandom_range(3))
            0:       return low[CFG_DATA_W-1:0];
            1:       return high[CFG_DATA_W-1:0];
            default: return CFG_DATA_W'($urandom_range(high, low));
        endcase
    endfunction

    // Mostly rising runs with drops mixed in, so the window walks through
    // growth, probes and decreases; a few full-range samples as noise.
    function automatic logic [RATE_W-1:0] next_rate();
        int unsigned       roll;
        logic [RATE_W-1:0] step;
        roll = $urandom_range(99);
        if (roll < 55)
        begin
            step = $urandom_range(4096, 1);
            return (prev_sent > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : prev_sent + step;
        end
        else if (roll < 85)
            return $urandom_range(prev_sent, 0);
        else if (roll < 90)
            return prev_sent;
        else
            return $urandom;
    endfunction

    initial
    begin
        rst_n           <= 1'b0;
        wr_en           <= 1'b0;
        wr_index        <= REG_THREAD_COUNT;
        wr_data         <= '0;
        sample_ch.valid <= 1'b0;
        sample_ch.rate  <= '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Slow start from a window of one up to all 64 threads; the last
        // doubling wakes 32 threads in one burst.
        for (int i = 0; i < 6; i++)
            send_rate(i);
        // window at the cap: no growth
        send_rate(32'hFFFF_FFFF);
        // drop in slow start: multiplicative decrease, slow start ends
        send_rate(32'd0);
        // first drop after slow start: probing step back
        send_rate(32'd0);
        // rise while probing: the decrease is avoided
        send_rate(32'hFFFF_FFFF);
        // probe again, then a drop while probing cuts the window
        send_rate(32'd0);
        send_rate(32'd0);

        // Thread count zero acts as one, window stays above it; zero divisor
        // and zero drop limit.
        write_settings(8'd0, 8'hFF, 8'd0, 8'd0);
        send_rate(32'd7);
        send_rate(32'd0);
        send_rate(32'd0);

        // First thread beyond the thread count; the largest divisor cuts to one,
        // then growth wakes wrap around the ten threads.
        write_settings(8'd10, 8'd63, 8'd255, 8'd3);
        for (int i = 0; i < 4; i++)
            send_rate(32'd0);
        for (int i = 1; i <= 3; i++)
            send_rate(i);

        // Oversized thread count clamps to 64; the largest drop limit lets drops
        // pile up, then lowering the limit fires the decrease on the next drop.
        write_settings(8'hFF, 8'hC0, 8'd16, 8'd255);
        send_rate(32'd3);
        send_rate(32'd2);
        send_rate(32'd1);
        write_settings(8'hFF, 8'hC0, 8'd16, 8'd2);
        send_rate(32'd0);

        // Random part: a fresh register setting per phase; idle mix swaps
        // sides after a third and stops for the last third.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_settings(pick_setting(1, MAX_THREADS), pick_setting(0, 255),
                           pick_setting(16, 255), pick_setting(1, 4));
            if (p < RANDOM_PHASES / 3)
            begin
                send_idle_pct = 33;
                recv_idle_pct = 51;
            end
            else if (p < 2 * RANDOM_PHASES / 3)
            begin
                send_idle_pct = 51;
                recv_idle_pct = 33;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int i = 0; i < RATES_PER_PHASE; i++)
            begin
                if ($urandom_range(29) == 0)
                    drain();
                send_rate(next_rate());
            end
        end

        // Let everything come back, then watch a while for stray results.
        drain();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("covered %0d rate samples under %0d register settings, with and without idling",
                 rates_sent, settings_used);
        $display("%0d results compared, %0d of them thread wakes",
                 results_checked, wakes_checked);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/aptw_pkg.sv
src/aptw_if.sv
src/aptw_div.sv
src/aptw_ctrl.sv
src/aptw_dp.sv
src/aimd_probe_thread_window_control_top.sv
tb/thread_window_checker.sv
tb/aimd_probe_thread_window_control_top_tb.sv
